// ----- hw/rtl/jsud_pkg.sv -----
// ----------------------------------------------------------------------------
// jsud_pkg
// Shared types and codes for the JSON string unescape decoder.
// ----------------------------------------------------------------------------
package jsud_pkg;

    typedef enum logic [3:0] {
        MODE_IDLE   = 4'd0,
        MODE_BODY   = 4'd1,
        MODE_ESC    = 4'd2,
        MODE_HEX1   = 4'd3,
        MODE_WANTBS = 4'd4,
        MODE_WANTU  = 4'd5,
        MODE_HEX2   = 4'd6
    } mode_t;

    localparam logic [1:0] ST_BYTE  = 2'd0;
    localparam logic [1:0] ST_CLOSE = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    localparam int MAX_RES = 4;
    localparam int CNT_W   = 3;

    typedef struct packed {
        mode_t       mode;
        logic [15:0] code_unit;
        logic [15:0] high_half;
        logic [1:0]  digit_count;
    } dec_state_t;

    // One group of result words caused by one input word
    typedef struct packed {
        logic [CNT_W-1:0]          cnt;
        logic [1:0]                status;
        logic [MAX_RES-1:0][7:0]   bytes;
    } res_group_t;

endpackage

// ----- hw/rtl/jsud_decode.sv -----
// ----------------------------------------------------------------------------
// jsud_decode
// Single-pass decode of one input word: next state and up to four results.
// ----------------------------------------------------------------------------
module jsud_decode
(
    input  jsud_pkg::dec_state_t st,
    input  logic                 op,
    input  logic [7:0]           in_byte,
    output jsud_pkg::dec_state_t st_next,
    output jsud_pkg::res_group_t res
);

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CTRL_LIM = 8'h20;

    localparam logic [15:0] HI_LO = 16'hD800;
    localparam logic [15:0] HI_HI = 16'hDBFF;
    localparam logic [15:0] LO_LO = 16'hDC00;
    localparam logic [15:0] LO_HI = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE = 21'h10000;
    localparam logic [20:0] LIM1 = 21'h7F;
    localparam logic [20:0] LIM2 = 21'h7FF;
    localparam logic [20:0] LIM3 = 21'hFFFF;

    logic        hex_ok;
    logic [3:0]  hex_d;
    logic [15:0] cu_new;
    logic        is_high;
    logic        is_low;
    logic [20:0] cp;
    logic        err;

    function automatic jsud_pkg::res_group_t encode(input logic [20:0] c);
        jsud_pkg::res_group_t r;
        r = '0;
        r.status = jsud_pkg::ST_BYTE;
        if (c <= LIM1) begin
            r.cnt = 3'd1;
            r.bytes[0] = c[7:0];
        end else if (c <= LIM2) begin
            r.cnt = 3'd2;
            r.bytes[0] = {3'b110, c[10:6]};
            r.bytes[1] = {2'b10, c[5:0]};
        end else if (c <= LIM3) begin
            r.cnt = 3'd3;
            r.bytes[0] = {4'b1110, c[15:12]};
            r.bytes[1] = {2'b10, c[11:6]};
            r.bytes[2] = {2'b10, c[5:0]};
        end else begin
            r.cnt = 3'd4;
            r.bytes[0] = {5'b11110, c[20:18]};
            r.bytes[1] = {2'b10, c[17:12]};
            r.bytes[2] = {2'b10, c[11:6]};
            r.bytes[3] = {2'b10, c[5:0]};
        end
        return r;
    endfunction

    always_comb
    begin
        hex_ok = 1'b1;
        hex_d  = 4'd0;
        if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
            hex_d = in_byte[3:0];
        end else if ((in_byte >= 8'h61 && in_byte <= 8'h66)
                     || (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
            hex_d = in_byte[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign cu_new  = {st.code_unit[11:0], hex_d};
    assign is_high = (cu_new >= HI_LO) && (cu_new <= HI_HI);
    assign is_low  = (cu_new >= LO_LO) && (cu_new <= LO_HI);

    // surrogate pair: high_half - D800 is just its low ten bits
    assign cp = (st.mode == jsud_pkg::MODE_HEX2)
              ? ({1'b0, st.high_half[9:0], cu_new[9:0]} + SUPP_BASE)
              : {5'd0, cu_new};

    always_comb
    begin
        st_next = st;
        res     = '0;
        res.status = jsud_pkg::ST_BYTE;
        err     = 1'b0;

        if (op) begin
            err = 1'b1;
        end else begin
            unique case (st.mode)
                jsud_pkg::MODE_BODY:
                begin
                    if (in_byte == CH_QUOTE) begin
                        st_next      = '0;
                        st_next.mode = jsud_pkg::MODE_IDLE;
                        res.cnt      = 3'd1;
                        res.status   = jsud_pkg::ST_CLOSE;
                    end else if (in_byte < CTRL_LIM) begin
                        err = 1'b1;
                    end else if (in_byte == CH_BSL) begin
                        st_next.mode = jsud_pkg::MODE_ESC;
                    end else begin
                        res.cnt      = 3'd1;
                        res.bytes[0] = in_byte;
                    end
                end
                jsud_pkg::MODE_ESC:
                begin
                    st_next.mode = jsud_pkg::MODE_BODY;
                    res.cnt      = 3'd1;
                    unique case (in_byte)
                        CH_QUOTE, CH_BSL, CH_SLASH: res.bytes[0] = in_byte;
                        CH_B: res.bytes[0] = 8'h08;
                        CH_F: res.bytes[0] = 8'h0C;
                        CH_N: res.bytes[0] = 8'h0A;
                        CH_R: res.bytes[0] = 8'h0D;
                        CH_T: res.bytes[0] = 8'h09;
                        CH_U:
                        begin
                            res.cnt             = 3'd0;
                            st_next.mode        = jsud_pkg::MODE_HEX1;
                            st_next.code_unit   = 16'd0;
                            st_next.digit_count = 2'd0;
                        end
                        default: err = 1'b1;
                    endcase
                end
                jsud_pkg::MODE_HEX1, jsud_pkg::MODE_HEX2:
                begin
                    if (!hex_ok) begin
                        err = 1'b1;
                    end else if (st.digit_count != 2'd3) begin
                        st_next.code_unit   = cu_new;
                        st_next.digit_count = st.digit_count + 2'd1;
                    end else begin
                        st_next.digit_count = 2'd0;
                        if (st.mode == jsud_pkg::MODE_HEX1 && is_high) begin
                            st_next.high_half = cu_new;
                            st_next.code_unit = 16'd0;
                            st_next.mode      = jsud_pkg::MODE_WANTBS;
                        end else if ((st.mode == jsud_pkg::MODE_HEX1 && is_low)
                                     || (st.mode == jsud_pkg::MODE_HEX2 && !is_low)) begin
                            err = 1'b1;
                        end else begin
                            st_next.mode      = jsud_pkg::MODE_BODY;
                            st_next.code_unit = 16'd0;
                            st_next.high_half = 16'd0;
                            res               = encode(cp);
                        end
                    end
                end
                jsud_pkg::MODE_WANTBS:
                begin
                    if (in_byte != CH_BSL) begin
                        err = 1'b1;
                    end else begin
                        st_next.mode = jsud_pkg::MODE_WANTU;
                    end
                end
                jsud_pkg::MODE_WANTU:
                begin
                    if (in_byte != CH_U) begin
                        err = 1'b1;
                    end else begin
                        st_next.mode        = jsud_pkg::MODE_HEX2;
                        st_next.code_unit   = 16'd0;
                        st_next.digit_count = 2'd0;
                    end
                end
                default:
                begin
                    if (in_byte != CH_QUOTE) begin
                        err = 1'b1;
                    end else begin
                        st_next      = '0;
                        st_next.mode = jsud_pkg::MODE_BODY;
                    end
                end
            endcase
        end

        if (err) begin
            st_next      = '0;
            st_next.mode = jsud_pkg::MODE_IDLE;
            res          = '0;
            res.cnt      = 3'd1;
            res.status   = jsud_pkg::ST_ERROR;
        end
    end

endmodule

// ----- hw/rtl/jsud_out_buf.sv -----
// ----------------------------------------------------------------------------
// jsud_out_buf
// Result register: holds one group of up to four words and sends them in turn.
// ----------------------------------------------------------------------------
module jsud_out_buf
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  jsud_pkg::res_group_t grp,
    output logic                 free,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,  // [7:0] out_byte
    output logic [1:0]           m_axis_tuser,  // [1:0] status
    output logic                 m_axis_tlast
);

    logic [jsud_pkg::CNT_W-1:0]         cnt_reg, cnt_next;
    logic [1:0]                         status_reg, status_next;
    logic [jsud_pkg::MAX_RES-1:0][7:0]  bytes_reg, bytes_next;
    logic                               pop;

    assign pop  = m_axis_tvalid && m_axis_tready;
    assign free = (cnt_reg == '0) || (cnt_reg == 3'd1 && m_axis_tready);

    always_comb
    begin
        cnt_next    = cnt_reg;
        status_next = status_reg;
        bytes_next  = bytes_reg;
        if (load) begin
            cnt_next    = grp.cnt;
            status_next = grp.status;
            bytes_next  = grp.bytes;
        end else if (pop) begin
            cnt_next   = cnt_reg - 3'd1;
            bytes_next = {8'd0, bytes_reg[jsud_pkg::MAX_RES-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        bytes_reg  <= bytes_next;
    end

    assign m_axis_tvalid = (cnt_reg != '0);
    assign m_axis_tdata  = bytes_reg[0];
    assign m_axis_tuser  = status_reg;
    assign m_axis_tlast  = (cnt_reg == 3'd1);

endmodule

// ----- hw/rtl/json_string_unescape_decoder_unit.sv -----
// Path: the input word is registered, decoded, and its results are registered.
// Throughput: one input word per cycle while each yields at most one result and
// the receiver is ready; a word yielding n results (n up to 4, from a \u escape)
// holds the output port until the group output register has sent them all.
// Reset: asynchronous, active low; decoder returns to idle awaiting a quote.
// ----------------------------------------------------------------------------
// json_string_unescape_decoder_unit
// Decodes a quoted JSON string token into UTF-8 bytes, close and error marks.
// ----------------------------------------------------------------------------
module json_string_unescape_decoder_unit
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tuser,   // [0] op
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [1:0] m_axis_tuser,   // [1:0] status
    output logic       m_axis_tlast
);

    logic                 in_vld_reg, in_vld_next;
    logic                 op_reg;
    logic [7:0]           byte_reg;
    logic                 take;
    logic                 advance;
    logic                 buf_free;
    jsud_pkg::dec_state_t st_reg, st_next, dec_st;
    jsud_pkg::res_group_t dec_res;

    jsud_decode u_dec
    (
        .st      (st_reg),
        .op      (op_reg),
        .in_byte (byte_reg),
        .st_next (dec_st),
        .res     (dec_res)
    );

    // an item with no result never waits for the output side
    assign advance       = in_vld_reg && (buf_free || dec_res.cnt == '0);
    assign s_axis_tready = !in_vld_reg || advance;
    assign take          = s_axis_tvalid && s_axis_tready;
    assign in_vld_next   = take || (in_vld_reg && !advance);
    assign st_next       = advance ? dec_st : st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_vld_reg <= 1'b0;
            st_reg     <= '0;
        end else begin
            in_vld_reg <= in_vld_next;
            st_reg     <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take) begin
            op_reg   <= s_axis_tuser;
            byte_reg <= s_axis_tdata;
        end
    end

    jsud_out_buf u_obuf
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (advance && dec_res.cnt != '0),
        .grp           (dec_res),
        .free          (buf_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the JSON string unescape decoder. Quoted tokens with
// random content, escapes and surrogate pairs are fed in, mixed with broken
// tokens and stray bytes. Every output word is checked in order against a
// local model of the decoder under several sender and receiver idle patterns.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CLK_HALF    = 10;
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;

    localparam logic [7:0] QUOTE  = 8'h22;
    localparam logic [7:0] BSLASH = 8'h5C;
    localparam logic [63:0] SIMPLE_ESC = "\"\\/bfnrt";

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] status;
        logic       last;
    } utf8_word_t;

    typedef struct packed {
        logic       op;
        logic [7:0] data;
    } text_word_t;

    // Decoder model plus queue of UTF-8 words still owed by the block
    class utf8_scoreboard;
        jsud_pkg::mode_t mode;
        logic [15:0]     code_unit;
        logic [15:0]     high_half;
        logic [1:0]      digit_count;
        utf8_word_t      pending[$];
        int              mismatches;

        function new();
            clear_state();
            mismatches = 0;
        endfunction

        function void clear_state();
            mode        = jsud_pkg::MODE_IDLE;
            code_unit   = 16'h0;
            high_half   = 16'h0;
            digit_count = 2'd0;
        endfunction

        function void queue_word(logic [7:0] d, logic [1:0] s, logic l);
            utf8_word_t w;
            w.data   = d;
            w.status = s;
            w.last   = l;
            pending  = {pending, w};
        endfunction

        function void queue_error();
            clear_state();
            queue_word(8'h00, jsud_pkg::ST_ERROR, 1'b1);
        endfunction

        function int nibble_value(logic [7:0] c);
            if (c >= "0" && c <= "9")
                return c - "0";
            if (c >= "a" && c <= "f")
                return c - "a" + 10;
            if (c >= "A" && c <= "F")
                return c - "A" + 10;
            return -1;
        endfunction

        function void queue_code_point(logic [20:0] cp);
            logic [7:0] seq [4];
            int         n;
            if (cp <= 21'h7F)
            begin
                seq[0] = cp[7:0];
                n = 1;
            end
            else if (cp <= 21'h7FF)
            begin
                seq[0] = {3'b110, cp[10:6]};
                seq[1] = {2'b10, cp[5:0]};
                n = 2;
            end
            else if (cp <= 21'hFFFF)
            begin
                seq[0] = {4'b1110, cp[15:12]};
                seq[1] = {2'b10, cp[11:6]};
                seq[2] = {2'b10, cp[5:0]};
                n = 3;
            end
            else
            begin
                seq[0] = {5'b11110, cp[20:18]};
                seq[1] = {2'b10, cp[17:12]};
                seq[2] = {2'b10, cp[11:6]};
                seq[3] = {2'b10, cp[5:0]};
                n = 4;
            end
            for (int i = 0; i < n; i++)
                queue_word(seq[i], jsud_pkg::ST_BYTE, i == n - 1);
        endfunction

        // Accepted input word: work out what the decoder owes for it
        function void note_word(logic op, logic [7:0] c);
            int          d;
            logic [20:0] cp;
            if (op)
            begin
                queue_error();
                return;
            end
            case (mode)
                jsud_pkg::MODE_BODY:
                begin
                    if (c == QUOTE)
                    begin
                        clear_state();
                        queue_word(8'h00, jsud_pkg::ST_CLOSE, 1'b1);
                    end
                    else if (c < 8'h20)
                        queue_error();
                    else if (c == BSLASH)
                        mode = jsud_pkg::MODE_ESC;
                    else
                        queue_word(c, jsud_pkg::ST_BYTE, 1'b1);
                end
                jsud_pkg::MODE_ESC:
                begin
                    case (c)
                        QUOTE, BSLASH, "/":
                        begin
                            mode = jsud_pkg::MODE_BODY;
                            queue_word(c, jsud_pkg::ST_BYTE, 1'b1);
                        end
                        "b", "f", "n", "r", "t":
                        begin
                            mode = jsud_pkg::MODE_BODY;
                            case (c)
                                "b": queue_word(8'h08, jsud_pkg::ST_BYTE, 1'b1);
                                "f": queue_word(8'h0C, jsud_pkg::ST_BYTE, 1'b1);
                                "n": queue_word(8'h0A, jsud_pkg::ST_BYTE, 1'b1);
                                "r": queue_word(8'h0D, jsud_pkg::ST_BYTE, 1'b1);
                                default: queue_word(8'h09, jsud_pkg::ST_BYTE, 1'b1);
                            endcase
                        end
                        "u":
                        begin
                            mode        = jsud_pkg::MODE_HEX1;
                            code_unit   = 16'h0;
                            digit_count = 2'd0;
                        end
                        default:
                            queue_error();
                    endcase
                end
                jsud_pkg::MODE_HEX1, jsud_pkg::MODE_HEX2:
                begin
                    d = nibble_value(c);
                    if (d < 0)
                        queue_error();
                    else
                    begin
                        code_unit = {code_unit[11:0], d[3:0]};
                        if (digit_count != 2'd3)
                            digit_count++;
                        else
                        begin
                            digit_count = 2'd0;
                            if (mode == jsud_pkg::MODE_HEX1 && code_unit >= 16'hD800
                                && code_unit <= 16'hDBFF)
                            begin
                                high_half = code_unit;
                                code_unit = 16'h0;
                                mode      = jsud_pkg::MODE_WANTBS;
                            end
                            else if (mode == jsud_pkg::MODE_HEX1 && code_unit >= 16'hDC00
                                     && code_unit <= 16'hDFFF)
                                queue_error();
                            else if (mode == jsud_pkg::MODE_HEX2
                                     && (code_unit < 16'hDC00 || code_unit > 16'hDFFF))
                                queue_error();
                            else
                            begin
                                if (mode == jsud_pkg::MODE_HEX1)
                                    cp = 21'(code_unit);
                                else
                                    cp = 21'h10000
                                         + ((21'(high_half) - 21'hD800) << 10)
                                         + (21'(code_unit) - 21'hDC00);
                                mode      = jsud_pkg::MODE_BODY;
                                code_unit = 16'h0;
                                high_half = 16'h0;
                                queue_code_point(cp);
                            end
                        end
                    end
                end
                jsud_pkg::MODE_WANTBS:
                begin
                    if (c != BSLASH)
                        queue_error();
                    else
                        mode = jsud_pkg::MODE_WANTU;
                end
                jsud_pkg::MODE_WANTU:
                begin
                    if (c != "u")
                        queue_error();
                    else
                    begin
                        mode        = jsud_pkg::MODE_HEX2;
                        code_unit   = 16'h0;
                        digit_count = 2'd0;
                    end
                end
                default:
                begin
                    // idle and unused codes: only an opening quote is taken
                    if (c != QUOTE)
                        queue_error();
                    else
                    begin
                        clear_state();
                        mode = jsud_pkg::MODE_BODY;
                    end
                end
            endcase
        endfunction

        function void report(string what, utf8_word_t want, utf8_word_t got);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t %s: expected %02h/%0d/%0b, got %02h/%0d/%0b",
                         $time, what, want.data, want.status, want.last,
                         got.data, got.status, got.last);
        endfunction

        function void check_word(logic [7:0] d, logic [1:0] s, logic l);
            utf8_word_t got;
            utf8_word_t want;
            got.data   = d;
            got.status = s;
            got.last   = l;
            if (pending.size() == 0)
            begin
                want = '0;
                report("unexpected word", want, got);
            end
            else
            begin
                want = pending.pop_front();
                if (want.data !== got.data || want.status !== got.status
                    || want.last !== got.last)
                    report("mismatch", want, got);
            end
        endfunction
    endclass

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;
    logic       s_axis_tuser  = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;
    logic       m_axis_tlast;

    int             src_idle_pct   = 0;
    int             sink_stall_pct = 0;
    int             idle_cycles    = 0;
    text_word_t     text_words[$];
    utf8_scoreboard sb;

    json_string_unescape_decoder_unit u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);

    always @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            sb.note_word(s_axis_tuser, s_axis_tdata);
        if (m_axis_tvalid && m_axis_tready)
            sb.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("tb: failure");
        $finish;
    end

    function void append_text(text_word_t w);
        text_words = {text_words, w};
    endfunction

    function void add_byte(logic [7:0] c);
        text_word_t w;
        w.op   = 1'b0;
        w.data = c;
        append_text(w);
    endfunction

    function void add_end();
        text_word_t w;
        w.op   = 1'b1;
        w.data = 8'($urandom_range(255));
        append_text(w);
    endfunction

    function logic [7:0] hex_char(logic [3:0] n);
        if (n < 4'd10)
            return 8'h30 + n;
        return ($urandom_range(1) ? 8'h61 : 8'h41) + n - 8'd10;
    endfunction

    function void add_unicode(logic [15:0] v);
        add_byte(BSLASH);
        add_byte("u");
        for (int i = 3; i >= 0; i--)
            add_byte(hex_char(v[4*i +: 4]));
    endfunction

    function logic [15:0] pick_bmp();
        logic [15:0] edges [8];
        edges = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF,
                  16'h0800, 16'hD7FF, 16'hE000, 16'hFFFF};
        if ($urandom_range(7) == 0)
            return edges[$urandom_range(7)];
        case ($urandom_range(3))
            0: return 16'($urandom_range(16'h007F));
            1: return 16'($urandom_range(16'h07FF, 16'h0080));
            2: return 16'($urandom_range(16'hD7FF, 16'h0800));
            default: return 16'($urandom_range(16'hFFFF, 16'hE000));
        endcase
    endfunction

    function logic [15:0] pick_surrogate(logic low_half);
        logic [15:0] base;
        base = low_half ? 16'hDC00 : 16'hD800;
        case ($urandom_range(7))
            0: return base;
            1: return base + 16'h03FF;
            default: return base + 16'($urandom_range(16'h03FF));
        endcase
    endfunction

    function logic [7:0] pick_non_hex();
        case ($urandom_range(3))
            0: return 8'($urandom_range(8'h2F, 8'h00));
            1: return 8'($urandom_range(8'h40, 8'h3A));
            2: return 8'($urandom_range(8'h60, 8'h47));
            default: return 8'($urandom_range(8'hFF, 8'h67));
        endcase
    endfunction

    function logic [7:0] pick_bad_escape();
        logic [7:0] c;
        logic       named;
        do
        begin
            c = 8'($urandom_range(255));
            named = (c == "u");
            for (int i = 0; i < 8; i++)
                if (SIMPLE_ESC[8*i +: 8] == c)
                    named = 1'b1;
        end
        while (named);
        return c;
    endfunction

    // Token cut short by one of the error cases
    function void add_broken_tail();
        logic [15:0] v;
        case ($urandom_range(7))
            0: add_byte(8'($urandom_range(8'h1F)));
            1:
            begin
                add_byte(BSLASH);
                add_byte(pick_bad_escape());
            end
            2:
            begin
                v = pick_bmp();
                add_byte(BSLASH);
                add_byte("u");
                for (int i = $urandom_range(3); i > 0; i--)
                    add_byte(hex_char(v[4*i-1 -: 4]));
                add_byte(pick_non_hex());
            end
            3: add_unicode(pick_surrogate(1'b1));
            4:
            begin
                add_unicode(pick_surrogate(1'b0));
                v[7:0] = 8'($urandom_range(255));
                add_byte(v[7:0] == BSLASH ? v[7:0] ^ 8'h01 : v[7:0]);
            end
            5:
            begin
                add_unicode(pick_surrogate(1'b0));
                add_byte(BSLASH);
                v[7:0] = 8'($urandom_range(255));
                add_byte(v[7:0] == "u" ? v[7:0] ^ 8'h01 : v[7:0]);
            end
            6:
            begin
                add_unicode(pick_surrogate(1'b0));
                add_unicode($urandom_range(1) ? 16'($urandom_range(16'hDBFF))
                                              : 16'($urandom_range(16'hFFFF, 16'hE000)));
            end
            default: add_end();
        endcase
    endfunction

    function void add_token();
        logic [7:0] c;
        add_byte(QUOTE);
        repeat ($urandom_range(6, 1))
        begin
            case ($urandom_range(9))
                0, 1, 2, 3:
                begin
                    c = 8'($urandom_range(8'hFF, 8'h20));
                    add_byte(c == QUOTE || c == BSLASH ? c ^ 8'h01 : c);
                end
                4, 5:
                begin
                    add_byte(BSLASH);
                    add_byte(SIMPLE_ESC[8*$urandom_range(7) +: 8]);
                end
                6, 7, 8: add_unicode(pick_bmp());
                default:
                begin
                    add_unicode(pick_surrogate(1'b0));
                    add_unicode(pick_surrogate(1'b1));
                end
            endcase
        end
        if ($urandom_range(99) < 82)
            add_byte(QUOTE);
        else
            add_broken_tail();
    endfunction

    function void build_random(int n);
        logic [7:0] c;
        while (text_words.size() < n)
        begin
            // stray words between tokens
            if ($urandom_range(9) == 0)
            begin
                c = 8'($urandom_range(255));
                if ($urandom_range(1))
                    add_end();
                else
                    add_byte(c == QUOTE ? c ^ 8'h01 : c);
            end
            add_token();
        end
    endfunction

    function void load_directed();
        add_end();                          // end of input with no token
        add_byte("x");                      // no opening quote
        add_byte(QUOTE);
        add_byte(8'hFF);
        add_byte(8'h1F);                    // control byte
        add_byte(QUOTE);
        add_byte(BSLASH);
        add_byte("g");                      // bad escape
        add_byte(QUOTE);
        add_unicode(16'hDC00);              // lone low surrogate
        add_byte(QUOTE);
        add_unicode(16'hDBFF);
        add_byte("x");                      // high surrogate left unpaired
        add_byte(QUOTE);
        add_end();                          // end of input inside a token
    endfunction

    task automatic send_word(input text_word_t w);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= w.op;
        s_axis_tdata  <= w.data;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Send the queued words, then hold off until the decoder has caught up
    task automatic play_words(input int src_pct, input int sink_pct);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        while (text_words.size() != 0)
            send_word(text_words.pop_front());
        s_axis_tvalid <= 1'b0;
        repeat (2) @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_directed();
        play_words(0, 0);
        build_random(52);
        play_words(0, 0);
        build_random(52);
        play_words(69, 0);
        build_random(52);
        play_words(0, 69);
        build_random(52);
        play_words(13, 13);

        repeat (8) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
